FILE: rtl/core/dwq_pkg.sv
// Shared types and codes of the deadline wait queue.
`default_nettype none

package dwq_pkg;

  localparam int DEADLINE_W = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_EDF  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_ORDER_MODE = 3'd0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_UPD  = 2'b10
  } phase_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic capture;
    logic commit;
    logic op;
    logic mode;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/dwq_cell.sv
// One queue slot: holds an entry, flags its own match and shifts with its neighbors.
`default_nettype none

module dwq_cell #(
  parameter int ID_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dwq_pkg::cell_ctl_t             ctl,
  input  wire logic [ID_BITS-1:0]             cmp_id,
  input  wire logic [dwq_pkg::DEADLINE_W-1:0] cmp_deadline,
  input  wire logic [ID_BITS-1:0]             new_id,
  input  wire logic [dwq_pkg::DEADLINE_W-1:0] new_deadline,
  input  wire logic [ID_BITS-1:0]             prev_id,
  input  wire logic [dwq_pkg::DEADLINE_W-1:0] prev_deadline,
  input  wire logic                           prev_valid,
  input  wire logic [ID_BITS-1:0]             next_id,
  input  wire logic [dwq_pkg::DEADLINE_W-1:0] next_deadline,
  input  wire logic                           next_valid,
  input  wire logic                           chain_in,
  output logic                                chain_out,
  output logic                                hit,
  output logic [ID_BITS-1:0]                  id,
  output logic [dwq_pkg::DEADLINE_W-1:0]      deadline,
  output logic                                valid
);

  logic [ID_BITS-1:0]             id_r, id_nxt;
  logic [dwq_pkg::DEADLINE_W-1:0] dl_r, dl_nxt;
  logic                           valid_r, valid_nxt;
  logic                           hit_r, hit_nxt;

  always_comb begin
    hit_nxt = hit_r;
    if (ctl.capture) begin
      if (ctl.op == dwq_pkg::OP_INSERT) begin
        hit_nxt = !valid_r || ((ctl.mode == dwq_pkg::MODE_EDF) && (dl_r >= cmp_deadline));
      end else begin
        hit_nxt = valid_r && (id_r == cmp_id);
      end
    end
  end

  always_comb begin
    id_nxt    = id_r;
    dl_nxt    = dl_r;
    valid_nxt = valid_r;
    if (ctl.commit) begin
      if (ctl.op == dwq_pkg::OP_INSERT) begin
        // cells past the insert point move one step toward the tail
        if (chain_in) begin
          id_nxt    = prev_id;
          dl_nxt    = prev_deadline;
          valid_nxt = prev_valid;
        end else if (hit_r) begin
          id_nxt    = new_id;
          dl_nxt    = new_deadline;
          valid_nxt = 1'b1;
        end
      end else if (chain_in || hit_r) begin
        // close the gap left by the removed entry
        id_nxt    = next_id;
        dl_nxt    = next_deadline;
        valid_nxt = next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

  assign chain_out = chain_in | hit_r;
  assign hit       = hit_r;
  assign id        = id_r;
  assign deadline  = dl_r;
  assign valid     = valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/deadline_wait_queue_top.sv
// Deadline wait queue: a row of shifting cells with a two-phase sequencer and stream ports.
// Each transaction runs in two phases: at acceptance every cell compares the
// request against its own entry and registers a match flag; in the update
// phase, once the output register is free, the first match is found along the
// cell row, the cells from it toward the tail shift in place and the result is
// written into the output register. A new request is taken only once the
// update is made; none is taken while another is in progress. In FIFO mode (order_mode 0)
// inserts go to the tail; in EDF mode (order_mode 1) an insert goes before
// the first entry whose deadline is not earlier than its own. A remove
// deletes the entry nearest the head with the given id. The queue holds
// QUEUE_DEPTH entries; its storage needs no clearing after reset.
`default_nettype none

module deadline_wait_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: op, requester_id, deadline (zero padded to whole bytes)
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((ID_BITS+dwq_pkg::DEADLINE_W+8)/8)*8-1:0] in_tdata,
  // out_tdata: status, head_freed, head_valid, head_id, occupancy (zero padded)
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((ID_BITS+$clog2(QUEUE_DEPTH+1)+11)/8)*8-1:0] out_tdata,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [dwq_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DL_W   = dwq_pkg::DEADLINE_W;
  localparam int OUT_RW = dwq_pkg::STATUS_W + 2 + ID_BITS + CNT_W;
  localparam int OUT_W  = ((ID_BITS + CNT_W + 11) / 8) * 8;

  // input unpack
  logic              in_op;
  logic [ID_BITS-1:0] in_id;
  logic [DL_W-1:0]   in_dl;
  assign in_op = in_tdata[0];
  assign in_id = in_tdata[ID_BITS:1];
  assign in_dl = in_tdata[ID_BITS+DL_W:ID_BITS+1];

  // configuration
  logic mode_r, mode_nxt;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mode_nxt   = (cfg_wr && (cfg_paddr == dwq_pkg::REG_ORDER_MODE)) ? cfg_pwdata[0]
                                                                          : mode_r;
  assign cfg_prdata = (cfg_paddr == dwq_pkg::REG_ORDER_MODE) ? {31'd0, mode_r} : 32'd0;

  // sequencer state
  dwq_pkg::phase_t    ph_r, ph_nxt;
  logic               op_r, op_nxt;
  logic [ID_BITS-1:0] cid_r, cid_nxt;
  logic [DL_W-1:0]    cdl_r, cdl_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_RW-1:0]  out_data_r, out_data_nxt;

  logic accept, done_now, full, found, apply;
  dwq_pkg::cell_ctl_t ctl;

  // cell row wiring
  logic [ID_BITS-1:0] cell_id    [QUEUE_DEPTH];
  logic [DL_W-1:0]    cell_dl    [QUEUE_DEPTH];
  logic               cell_valid [QUEUE_DEPTH];
  logic               cell_hit   [QUEUE_DEPTH];
  logic               chain      [QUEUE_DEPTH+1];

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] p_id, n_id;
    logic [DL_W-1:0]    p_dl, n_dl;
    logic               p_v, n_v;

    if (i == 0) begin : g_first
      assign p_id = '0;
      assign p_dl = '0;
      assign p_v  = 1'b0;
    end else begin : g_mid_p
      assign p_id = cell_id[i-1];
      assign p_dl = cell_dl[i-1];
      assign p_v  = cell_valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_id = '0;
      assign n_dl = '0;
      assign n_v  = 1'b0;
    end else begin : g_mid_n
      assign n_id = cell_id[i+1];
      assign n_dl = cell_dl[i+1];
      assign n_v  = cell_valid[i+1];
    end

    dwq_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .cmp_id       (in_id),
      .cmp_deadline (in_dl),
      .new_id       (cid_r),
      .new_deadline (cdl_r),
      .prev_id      (p_id),
      .prev_deadline(p_dl),
      .prev_valid   (p_v),
      .next_id      (n_id),
      .next_deadline(n_dl),
      .next_valid   (n_v),
      .chain_in     (chain[i]),
      .chain_out    (chain[i+1]),
      .hit          (cell_hit[i]),
      .id           (cell_id[i]),
      .deadline     (cell_dl[i]),
      .valid        (cell_valid[i])
    );
  end

  assign in_tready = (ph_r == dwq_pkg::PH_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign done_now  = (ph_r == dwq_pkg::PH_UPD) && (!out_valid_r || out_tready);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign found     = chain[QUEUE_DEPTH];
  assign apply     = (op_r == dwq_pkg::OP_INSERT) ? !full : found;

  assign ctl.capture = accept;
  assign ctl.commit  = done_now && apply;
  assign ctl.op      = accept ? in_op : op_r;
  assign ctl.mode    = mode_r;

  always_comb begin
    logic [dwq_pkg::STATUS_W-1:0] status;
    logic                         freed;
    logic [ID_BITS-1:0]           head;
    logic                         head_v;

    ph_nxt        = ph_r;
    op_nxt        = op_r;
    cid_nxt       = cid_r;
    cdl_nxt       = cdl_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    status        = dwq_pkg::ST_DONE;
    freed         = 1'b0;
    head          = cell_id[0];
    head_v        = 1'b0;

    unique case (ph_r)
      dwq_pkg::PH_IDLE: begin
        if (accept) begin
          op_nxt  = in_op;
          cid_nxt = in_id;
          cdl_nxt = in_dl;
          ph_nxt  = dwq_pkg::PH_UPD;
        end
      end
      dwq_pkg::PH_UPD: begin
        if (done_now) begin
          ph_nxt = dwq_pkg::PH_IDLE;
        end
      end
      default: ph_nxt = dwq_pkg::PH_IDLE;
    endcase

    if (op_r == dwq_pkg::OP_INSERT) begin
      if (!apply) begin
        status = dwq_pkg::ST_FULL;
      end else if (cell_hit[0]) begin
        head = cid_r;
      end
    end else begin
      if (!apply) begin
        status = dwq_pkg::ST_NOT_FOUND;
      end else if (cell_hit[0]) begin
        freed = 1'b1;
        head  = cell_id[1];
      end
    end

    if (done_now) begin
      if (apply) begin
        count_nxt = (op_r == dwq_pkg::OP_INSERT) ? count_r + CNT_W'(1) : count_r - CNT_W'(1);
      end
      head_v        = (count_nxt != '0);
      out_valid_nxt = 1'b1;
      out_data_nxt  = {count_nxt, head_v ? head : ID_BITS'(0), head_v, freed, status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= dwq_pkg::PH_IDLE;
      mode_r      <= dwq_pkg::MODE_FIFO;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      op_r        <= dwq_pkg::OP_INSERT;
    end else begin
      ph_r        <= ph_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cid_r      <= cid_nxt;
    cdl_r      <= cdl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - OUT_RW)'(0), out_data_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (count_r != '0))
    else $error("head cell valid disagrees with occupancy");

  a_tail_matches_full: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[QUEUE_DEPTH-1] == full)
    else $error("tail cell valid disagrees with full flag");

  a_commit_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    done_now |=> out_valid_r && (ph_r == dwq_pkg::PH_IDLE))
    else $error("update did not produce a result");
`endif

endmodule

`default_nettype wire
